// ----- rtl/core/dsdl_pkg.sv -----
// Shared constants, command codes and types for the dual-slot sensor debounce block.
// Used by dsdl_slot_check, dsdl_out_fifo and the top level; depends on nothing.
package dsdl_pkg;

  localparam int NUM_PINS    = 6;
  localparam int COUNT_WIDTH = 16;
  localparam int PIN_IDX_W   = $clog2(NUM_PINS);

  // Configuration registers are 16 bits, decoded on word addresses.
  localparam int REG_W      = 16;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam logic [REG_W-1:0] DEBOUNCE_RESET = 16'd5500;
  localparam logic [REG_W-1:0] LOCK_RESET     = 16'd20000;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_EDGE      = 2'd0,
    CMD_DB_TICK   = 2'd1,
    CMD_LOCK_TICK = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_LOCK     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [PIN_IDX_W-1:0] pin_index;
    logic                 slot;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic                 accept;
    logic [PIN_IDX_W-1:0] pin;
  } chk_t;

endpackage

// ----- rtl/core/dual_slot_sensor_debounce_lockout.sv -----
// Dual-slot sensor debouncer with per-pin lockout, top level.
// A result passes through the input register and the result queue before it can transfer out.
// Throughput: one input item per cycle; results leave one per cycle through a 4-entry
// queue unless out_stall is high; the input stalls while fewer than two entries are free.
// Reset (rst_n, synchronous): slots idle, no pin locked, delays back to 5500 and 20000.
// Uses dsdl_pkg, dsdl_slot_check and dsdl_out_fifo.
module dual_slot_sensor_debounce_lockout (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_cmd,
  input  logic [dsdl_pkg::NUM_PINS-1:0]   in_edge_flags,
  input  logic [dsdl_pkg::NUM_PINS-1:0]   in_pin_levels,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dsdl_pkg::PIN_IDX_W-1:0]  out_pin_index,
  output logic                            out_slot,
  output logic                            out_last,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [dsdl_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [dsdl_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [dsdl_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int NP = dsdl_pkg::NUM_PINS;
  localparam int CW = dsdl_pkg::COUNT_WIDTH;

  // Configuration registers.
  logic [dsdl_pkg::REG_W-1:0] debounce_delay_r;
  logic [dsdl_pkg::REG_W-1:0] lock_delay_r;
  dsdl_pkg::reg_idx_t         cfg_idx;
  logic                       cfg_wr;

  // Input register.
  logic                       in_vld_r;
  dsdl_pkg::cmd_t             in_cmd_r;
  logic [NP-1:0]              in_edge_flags_r;
  logic [NP-1:0]              in_pin_levels_r;
  logic                       in_xfer;
  logic                       process;

  // Block state.
  logic                       next_slot_r, next_slot_nxt;
  logic [1:0]                 slot_active_r, slot_active_nxt;
  logic [NP-1:0]              slot_mask_r [2];
  logic [NP-1:0]              slot_mask_nxt [2];
  logic [CW-1:0]              slot_count_r [2];
  logic [CW-1:0]              slot_count_nxt [2];
  logic [NP-1:0]              locked_mask_r, locked_mask_nxt;
  logic [CW-1:0]              lock_count_r [NP];
  logic [CW-1:0]              lock_count_nxt [NP];

  logic [NP-1:0]              lock_nz;
  logic [NP-1:0]              cap;
  logic [1:0]                 fire;
  logic                       acc_a, acc_b;
  logic [NP-1:0]              lock_a_vec, lock_b_vec;
  logic [CW-1:0]              db_load, lock_load;
  dsdl_pkg::chk_t             chk_a, chk_b;

  // Result queue signals.
  logic [1:0]                 push_cnt;
  dsdl_pkg::result_t          push0, push1, head;
  logic [dsdl_pkg::FIFO_CW-1:0] fifo_free;
  logic                       pop;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = dsdl_pkg::reg_idx_t'(cfg_paddr[dsdl_pkg::CFG_AW-1]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_delay_r <= dsdl_pkg::DEBOUNCE_RESET;
      lock_delay_r     <= dsdl_pkg::LOCK_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dsdl_pkg::REG_DEBOUNCE: debounce_delay_r <= cfg_pwdata[dsdl_pkg::REG_W-1:0];
        dsdl_pkg::REG_LOCK:     lock_delay_r     <= cfg_pwdata[dsdl_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dsdl_pkg::REG_DEBOUNCE: cfg_prdata = dsdl_pkg::CFG_DW'(debounce_delay_r);
      dsdl_pkg::REG_LOCK:     cfg_prdata = dsdl_pkg::CFG_DW'(lock_delay_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // A delay of zero behaves as one.
  always_comb begin
    db_load   = CW'(debounce_delay_r);
    lock_load = CW'(lock_delay_r);
    if (db_load == '0) begin
      db_load = CW'(1);
    end
    if (lock_load == '0) begin
      lock_load = CW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: the held item is worked on once two queue entries are free.
  // ---------------------------------------------------------------------------
  assign process  = in_vld_r && (fifo_free >= dsdl_pkg::FIFO_CW'(2));
  assign in_stall = in_vld_r && !process;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (process) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_cmd_r        <= dsdl_pkg::cmd_t'(in_cmd);
      in_edge_flags_r <= in_edge_flags;
      in_pin_levels_r <= in_pin_levels;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot checks: slot B sees the lock that slot A sets on the same tick.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      lock_nz[i] = (lock_count_r[i] != '0);
    end
    for (int s = 0; s < 2; s++) begin
      fire[s] = process && (in_cmd_r == dsdl_pkg::CMD_DB_TICK) && slot_active_r[s] &&
                (slot_count_r[s] <= CW'(1));
    end
  end

  dsdl_slot_check u_check_a (
    .mask_i      (slot_mask_r[0]),
    .levels_i    (in_pin_levels_r),
    .locked_i    (locked_mask_r),
    .lock_idle_i (~lock_nz),
    .pick_high_i (1'b0),
    .chk_o       (chk_a)
  );

  assign acc_a      = fire[0] && chk_a.accept;
  assign lock_a_vec = acc_a ? (NP'(1) << chk_a.pin) : '0;

  dsdl_slot_check u_check_b (
    .mask_i      (slot_mask_r[1]),
    .levels_i    (in_pin_levels_r),
    .locked_i    (locked_mask_r | lock_a_vec),
    .lock_idle_i (~lock_nz & ~lock_a_vec),
    .pick_high_i (1'b1),
    .chk_o       (chk_b)
  );

  assign acc_b      = fire[1] && chk_b.accept;
  assign lock_b_vec = acc_b ? (NP'(1) << chk_b.pin) : '0;

  // ---------------------------------------------------------------------------
  // State update
  // ---------------------------------------------------------------------------
  assign cap = in_edge_flags_r & ~locked_mask_r;

  always_comb begin
    next_slot_nxt   = next_slot_r;
    slot_active_nxt = slot_active_r;
    locked_mask_nxt = locked_mask_r;
    for (int s = 0; s < 2; s++) begin
      slot_mask_nxt[s]  = slot_mask_r[s];
      slot_count_nxt[s] = slot_count_r[s];
    end
    for (int i = 0; i < NP; i++) begin
      lock_count_nxt[i] = lock_count_r[i];
    end

    if (process) begin
      case (in_cmd_r)
        dsdl_pkg::CMD_EDGE: begin
          // A capture onto a busy slot restarts it.
          if (cap != '0) begin
            next_slot_nxt                 = ~next_slot_r;
            slot_mask_nxt[next_slot_r]    = cap;
            slot_count_nxt[next_slot_r]   = db_load;
            slot_active_nxt[next_slot_r]  = 1'b1;
          end
        end
        dsdl_pkg::CMD_DB_TICK: begin
          for (int s = 0; s < 2; s++) begin
            if (fire[s]) begin
              slot_count_nxt[s]  = '0;
              slot_active_nxt[s] = 1'b0;
            end else if (slot_active_r[s]) begin
              slot_count_nxt[s] = slot_count_r[s] - CW'(1);
            end
          end
          if (acc_a) begin
            slot_mask_nxt[0] = '0;
          end
          if (acc_b) begin
            slot_mask_nxt[1] = '0;
          end
          locked_mask_nxt = locked_mask_r | lock_a_vec | lock_b_vec;
          for (int i = 0; i < NP; i++) begin
            if (lock_a_vec[i] || lock_b_vec[i]) begin
              lock_count_nxt[i] = lock_load;
            end
          end
        end
        dsdl_pkg::CMD_LOCK_TICK: begin
          for (int i = 0; i < NP; i++) begin
            if (lock_count_r[i] == CW'(1)) begin
              lock_count_nxt[i]  = '0;
              locked_mask_nxt[i] = 1'b0;
            end else if (lock_nz[i]) begin
              lock_count_nxt[i] = lock_count_r[i] - CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_slot_r   <= 1'b0;
      slot_active_r <= '0;
      locked_mask_r <= '0;
      for (int s = 0; s < 2; s++) begin
        slot_mask_r[s]  <= '0;
        slot_count_r[s] <= '0;
      end
      for (int i = 0; i < NP; i++) begin
        lock_count_r[i] <= '0;
      end
    end else begin
      next_slot_r   <= next_slot_nxt;
      slot_active_r <= slot_active_nxt;
      locked_mask_r <= locked_mask_nxt;
      for (int s = 0; s < 2; s++) begin
        slot_mask_r[s]  <= slot_mask_nxt[s];
        slot_count_r[s] <= slot_count_nxt[s];
      end
      for (int i = 0; i < NP; i++) begin
        lock_count_r[i] <= lock_count_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Results: slot A first, the final result of a tick carries last.
  // ---------------------------------------------------------------------------
  always_comb begin
    push_cnt = {1'b0, acc_a} + {1'b0, acc_b};

    push0.pin_index = acc_a ? chk_a.pin : chk_b.pin;
    push0.slot      = !acc_a;
    push0.last      = !(acc_a && acc_b);

    push1.pin_index = chk_b.pin;
    push1.slot      = 1'b1;
    push1.last      = 1'b1;
  end

  dsdl_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (push1),
    .free_o     (fifo_free),
    .vld_o      (out_valid),
    .data_o     (head),
    .pop_i      (pop)
  );

  assign pop           = out_valid && !out_stall;
  assign out_pin_index = head.pin_index;
  assign out_slot      = head.slot;
  assign out_last      = head.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_lock_mask_matches_counts: assert property (
    @(posedge clk) disable iff (!rst_n) locked_mask_r == lock_nz
  ) else $error("locked mask disagrees with lockout counters");

  a_active_slot_has_mask: assert property (
    @(posedge clk) disable iff (!rst_n)
      (slot_active_r[0] |-> slot_mask_r[0] != '0) and
      (slot_active_r[1] |-> slot_mask_r[1] != '0)
  ) else $error("active debounce slot holds an empty mask");

  a_two_results_distinct_pins: assert property (
    @(posedge clk) disable iff (!rst_n)
      (push_cnt == 2'd2) |-> (push0.pin_index != push1.pin_index)
  ) else $error("both slots confirmed the same pin on one tick");

  a_stall_needs_held_item: assert property (
    @(posedge clk) disable iff (!rst_n)
      (in_stall && in_vld_r) |=> in_vld_r
  ) else $error("held input item lost while the input side was stalled");

endmodule

// ----- rtl/core/dsdl_slot_check.sv -----
// Expiry check of one debounce slot: level and lock tests plus the pin pick.
// Uses dsdl_pkg for widths and the chk_t result struct.
module dsdl_slot_check (
  input  logic [dsdl_pkg::NUM_PINS-1:0] mask_i,
  input  logic [dsdl_pkg::NUM_PINS-1:0] levels_i,
  input  logic [dsdl_pkg::NUM_PINS-1:0] locked_i,
  input  logic [dsdl_pkg::NUM_PINS-1:0] lock_idle_i,
  input  logic                          pick_high_i,
  output dsdl_pkg::chk_t                chk_o
);

  logic [dsdl_pkg::PIN_IDX_W-1:0] pin_lo;
  logic [dsdl_pkg::PIN_IDX_W-1:0] pin_hi;
  logic [dsdl_pkg::PIN_IDX_W-1:0] pin;

  // Priority encoders: the last hit in each loop wins.
  always_comb begin
    pin_lo = '0;
    pin_hi = '0;
    for (int i = dsdl_pkg::NUM_PINS - 1; i >= 0; i--) begin
      if (mask_i[i]) begin
        pin_lo = dsdl_pkg::PIN_IDX_W'(i);
      end
    end
    for (int i = 0; i < dsdl_pkg::NUM_PINS; i++) begin
      if (mask_i[i]) begin
        pin_hi = dsdl_pkg::PIN_IDX_W'(i);
      end
    end
  end

  assign pin          = pick_high_i ? pin_hi : pin_lo;
  assign chk_o.pin    = pin;
  assign chk_o.accept = ((levels_i & mask_i) != '0) && ((mask_i & locked_i) == '0) &&
                        lock_idle_i[pin];

endmodule

// ----- rtl/core/dsdl_out_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one per cycle when popped.
// Uses dsdl_pkg for the result_t entry type and the queue depth.
module dsdl_out_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     push_cnt_i,
  input  dsdl_pkg::result_t              push0_i,
  input  dsdl_pkg::result_t              push1_i,
  output logic [dsdl_pkg::FIFO_CW-1:0]   free_o,
  output logic                           vld_o,
  output dsdl_pkg::result_t              data_o,
  input  logic                           pop_i
);

  dsdl_pkg::result_t                mem [dsdl_pkg::FIFO_DEPTH];
  logic [dsdl_pkg::FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [dsdl_pkg::FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [dsdl_pkg::FIFO_CW-1:0]     cnt_r, cnt_nxt;
  logic [dsdl_pkg::FIFO_AW-1:0]     wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + dsdl_pkg::FIFO_AW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + dsdl_pkg::FIFO_AW'(push_cnt_i);
    rd_ptr_nxt = rd_ptr_r + dsdl_pkg::FIFO_AW'(pop_i);
    cnt_nxt    = cnt_r + dsdl_pkg::FIFO_CW'(push_cnt_i) - dsdl_pkg::FIFO_CW'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt_i != 2'd0) begin
      mem[wr_ptr_r] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem[wr_ptr_p1] <= push1_i;
    end
  end

  assign vld_o  = (cnt_r != '0);
  assign data_o = mem[rd_ptr_r];
  assign free_o = dsdl_pkg::FIFO_CW'(dsdl_pkg::FIFO_DEPTH) - cnt_r;

endmodule
